>>> sv/rsi_pkg.sv
// Shared types and constants for the RTP subflow header inserter.
// No dependencies; used by rsi_sched, rsi_core and the top level.
package rsi_pkg;

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int SEQ_W   = 16;
	localparam int POS_W   = 4;
	localparam int BURST_W = 5;

	// Fixed RTP header is 12 bytes; the emitted header with extension is 24
	localparam logic [POS_W-1:0]   POS_TWELFTH = 4'd11;
	localparam logic [POS_W-1:0]   POS_PAYLOAD = 4'd12;
	localparam logic [POS_W-1:0]   POS_START   = 4'd0;
	localparam logic [BURST_W-1:0] BURST_LAST  = 5'd23;
	localparam int                 HELD_DEPTH  = 11;

	// Header extension constants
	localparam logic [BYTE_W-1:0] EXT_FLAG    = 8'h10;
	localparam logic [BYTE_W-1:0] PROFILE_HI  = 8'hBE;
	localparam logic [BYTE_W-1:0] PROFILE_LO  = 8'hDE;
	localparam logic [BYTE_W-1:0] EXT_WORDS   = 8'h02;
	localparam logic [BYTE_W-1:0] ELEM_ID_LEN = 8'h04;
	localparam logic [BYTE_W-1:0] ELEM_MPID   = 8'h04;
	localparam logic [BYTE_W-1:0] ZERO_BYTE   = 8'h00;

	// Configuration register indexes
	localparam logic CFG_SEQ_FLOW0 = 1'b0;
	localparam logic CFG_SEQ_FLOW1 = 1'b1;

	// What one accepted byte does
	typedef enum logic [1:0] {
		KIND_HOLD,
		KIND_ERR,
		KIND_HDR,
		KIND_PASS
	} kind_t;

	// Current scheduler choice as seen by the emitter
	typedef struct packed {
		logic             flow;
		logic [SEQ_W-1:0] seq;
	} sched_t;

endpackage

>>> sv/rsi_sched.sv
// Round-robin subflow scheduler with per-subflow 16-bit sequence counters.
// Depends on rsi_pkg.
module rsi_sched (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [rsi_pkg::SEQ_W-1:0] cfg_wdata,
	input  logic                     advance,
	output rsi_pkg::sched_t          sched
);

	logic                      last_flow_q;
	logic [rsi_pkg::SEQ_W-1:0] seq0_q;
	logic [rsi_pkg::SEQ_W-1:0] seq1_q;
	logic                      flow;

	// Next subflow is the other one; first packet goes to subflow 1
	assign flow        = ~last_flow_q;
	assign sched.flow  = flow;
	assign sched.seq   = flow ? seq1_q : seq0_q;

	// Load counters on write, advance chosen counter when a header completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_flow_q <= 1'b0;
			seq0_q      <= '0;
			seq1_q      <= '0;
		end else begin
			if (advance) begin
				last_flow_q <= flow;
				if (flow) seq1_q <= seq1_q + 1'b1;
				else      seq0_q <= seq0_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					rsi_pkg::CFG_SEQ_FLOW0: seq0_q <= cfg_wdata;
					rsi_pkg::CFG_SEQ_FLOW1: seq1_q <= cfg_wdata;
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_flow_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> last_flow_q != $past(last_flow_q))
		else $error("scheduler did not alternate subflows");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && !cfg_we |=> $stable(seq0_q) && $stable(seq1_q) && $stable(last_flow_q))
		else $error("scheduler state moved without advance or write");
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !cfg_we && !flow |=> seq0_q == $past(seq0_q) + 16'd1)
		else $error("subflow 0 sequence did not step");
`endif

endmodule

>>> sv/rsi_core.sv
// Input stage, header hold store, extension burst sequencer and result register.
// Depends on rsi_pkg; takes the scheduler choice from rsi_sched.
module rsi_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rsi_pkg::BYTE_W-1:0] in_byte,
	input  logic                       in_last,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rsi_pkg::BYTE_W-1:0] out_byte,
	output logic                       out_last,
	output logic                       out_short,
	input  rsi_pkg::sched_t            sched,
	output logic                       advance
);

	logic [rsi_pkg::BYTE_W-1:0]  held_q [rsi_pkg::HELD_DEPTH];
	logic [rsi_pkg::POS_W-1:0]   pos_q;
	logic [rsi_pkg::BURST_W-1:0] burst_q;

	logic                        valid_s1;
	logic [rsi_pkg::BYTE_W-1:0]  byte_s1;
	logic                        last_s1;
	rsi_pkg::kind_t              kind_s1;

	logic                        out_valid_q;
	logic [rsi_pkg::BYTE_W-1:0]  out_byte_q;
	logic                        out_last_q;
	logic                        out_short_q;

	logic                        accept;
	logic                        slot_free;
	logic                        emit;
	logic                        burst_end;
	logic                        s1_done;
	rsi_pkg::kind_t              kind_in;
	logic [rsi_pkg::POS_W-1:0]   pos_next;
	logic [rsi_pkg::BYTE_W-1:0]  hdr_byte;
	logic [rsi_pkg::BYTE_W-1:0]  res_byte;
	logic                        res_last;

	// Handshake: the stage frees when its last beat moves to the result register, or at once for a held header byte
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = valid_s1 && (kind_s1 != rsi_pkg::KIND_HOLD) && slot_free;
	assign burst_end = (kind_s1 != rsi_pkg::KIND_HDR) || (burst_q == rsi_pkg::BURST_LAST);
	assign s1_done   = valid_s1 && ((kind_s1 == rsi_pkg::KIND_HOLD) || (emit && burst_end));
	assign in_ready  = !valid_s1 || s1_done;
	assign accept    = in_valid && in_ready;
	assign advance   = emit && (kind_s1 == rsi_pkg::KIND_HDR) &&
	                   (burst_q == rsi_pkg::BURST_LAST);

	// Classify the incoming byte by its place in the packet
	always_comb begin
		if (pos_q < rsi_pkg::POS_TWELFTH) begin
			kind_in  = in_last ? rsi_pkg::KIND_ERR : rsi_pkg::KIND_HOLD;
			pos_next = in_last ? rsi_pkg::POS_START : pos_q + 1'b1;
		end else begin
			kind_in  = (pos_q == rsi_pkg::POS_TWELFTH) ? rsi_pkg::KIND_HDR
			                                           : rsi_pkg::KIND_PASS;
			pos_next = in_last ? rsi_pkg::POS_START : rsi_pkg::POS_PAYLOAD;
		end
	end

	// Hold the first eleven header bytes
	always_ff @(posedge clk) begin
		if (accept && (pos_q < rsi_pkg::POS_TWELFTH)) begin
			held_q[pos_q] <= in_byte;
		end
	end

	// Track position, input stage and burst index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= rsi_pkg::POS_START;
			valid_s1 <= 1'b0;
			kind_s1  <= rsi_pkg::KIND_HOLD;
			burst_q  <= '0;
		end else begin
			if (accept) begin
				pos_q    <= pos_next;
				valid_s1 <= 1'b1;
				kind_s1  <= kind_in;
			end else if (s1_done) begin
				valid_s1 <= 1'b0;
			end
			if (emit && (kind_s1 == rsi_pkg::KIND_HDR)) begin
				burst_q <= burst_end ? '0 : burst_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Select the header byte for the current burst beat
	always_comb begin
		case (burst_q)
			5'd0:  hdr_byte = held_q[0] | rsi_pkg::EXT_FLAG;
			5'd1:  hdr_byte = held_q[1];
			5'd2:  hdr_byte = held_q[2];
			5'd3:  hdr_byte = held_q[3];
			5'd4:  hdr_byte = held_q[4];
			5'd5:  hdr_byte = held_q[5];
			5'd6:  hdr_byte = held_q[6];
			5'd7:  hdr_byte = held_q[7];
			5'd8:  hdr_byte = held_q[8];
			5'd9:  hdr_byte = held_q[9];
			5'd10: hdr_byte = held_q[10];
			5'd11: hdr_byte = byte_s1;
			5'd12: hdr_byte = rsi_pkg::PROFILE_HI;
			5'd13: hdr_byte = rsi_pkg::PROFILE_LO;
			5'd14: hdr_byte = rsi_pkg::ZERO_BYTE;
			5'd15: hdr_byte = rsi_pkg::EXT_WORDS;
			5'd16: hdr_byte = rsi_pkg::ELEM_ID_LEN;
			5'd17: hdr_byte = rsi_pkg::ELEM_MPID;
			5'd18: hdr_byte = rsi_pkg::ZERO_BYTE;
			5'd19: hdr_byte = {{(rsi_pkg::BYTE_W-1){1'b0}}, sched.flow};
			5'd20: hdr_byte = sched.seq[15:8];
			5'd21: hdr_byte = sched.seq[7:0];
			default: hdr_byte = rsi_pkg::ZERO_BYTE;
		endcase
	end

	// Pick the result beat by kind
	always_comb begin
		case (kind_s1)
			rsi_pkg::KIND_HDR: begin
				res_byte = hdr_byte;
				res_last = last_s1 && (burst_q == rsi_pkg::BURST_LAST);
			end
			rsi_pkg::KIND_PASS: begin
				res_byte = byte_s1;
				res_last = last_s1;
			end
			default: begin
				res_byte = rsi_pkg::ZERO_BYTE;
				res_last = 1'b1;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q  <= res_byte;
			out_last_q  <= res_last;
			out_short_q <= (kind_s1 == rsi_pkg::KIND_ERR);
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_short = out_short_q;

`ifndef SYNTHESIS
	a_burst_range: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q <= rsi_pkg::BURST_LAST)
		else $error("burst index out of range");
	a_burst_owner: assert property (@(posedge clk) disable iff (!arst_n)
		burst_q != '0 |-> valid_s1 && kind_s1 == rsi_pkg::KIND_HDR)
		else $error("burst running without a header item");
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= rsi_pkg::POS_PAYLOAD)
		else $error("byte position out of range");
	a_short_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_short_q |-> out_last_q && out_byte_q == rsi_pkg::ZERO_BYTE)
		else $error("error result not a zero end beat");
`endif

endmodule

>>> sv/rtp_subflow_header_inserter_unit.sv
// RTP subflow header inserter: top level.
// A byte passes through the input stage, then the result register.
// Throughput, while the output is ready: one byte per cycle; the twelfth header byte occupies
// the input stage while the burst sequencer emits the header and extension, one beat a cycle.
// Reset (arst_n, asynchronous, active low) clears position, scheduler and counters.
// Depends on rsi_pkg, rsi_sched and rsi_core.
module rtp_subflow_header_inserter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [rsi_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
	input  logic                       s_axis_tlast,   // last_byte
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [rsi_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] out_byte
	output logic                       m_axis_tlast,   // end_of_packet
	output logic                       m_axis_tuser,   // [0] short_packet
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [rsi_pkg::SEQ_W-1:0]  cfg_wdata
);

	rsi_pkg::sched_t sched;
	logic            advance;

	// Subflow choice and sequence counters
	rsi_sched u_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.advance   (advance),
		.sched     (sched)
	);

	// Byte path with header insertion
	rsi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_short (m_axis_tuser),
		.sched     (sched),
		.advance   (advance)
	);

endmodule
